// ===== design/assert_macros.svh =====
// assertion macros shared by the design files
// no dependencies; pulled in with an include by files that assert

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mbss_pkg.sv =====
// types and constants for the masked byte signature search
// no dependencies

`timescale 1ns / 1ps

package mbss_pkg;

    // bytes held by the three pattern registers
    localparam int REG_PATTERN_BYTES = 24;
    localparam int PATTERN_BITS      = 8 * REG_PATTERN_BYTES;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_PATTERN_LOW      = 3'd0,
        REG_PATTERN_MID      = 3'd1,
        REG_PATTERN_HIGH     = 3'd2,
        REG_CARE_MASK        = 3'd3,
        REG_PATTERN_LENGTH   = 3'd4,
        REG_EXTRACT_POSITION = 3'd5,
        REG_ADDRESS_MODE     = 3'd6,
        REG_BASE_ADDRESS     = 3'd7
    } t_cfg_reg;

    // result value selection
    typedef enum logic [1:0] {
        MODE_MATCH_ADDR = 2'd0,
        MODE_WORD       = 2'd1,
        MODE_ADDR_PLUS  = 2'd2
    } t_addr_mode;

    // result status codes
    localparam logic STATUS_FOUND     = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    // bytes in the extracted little-endian word
    localparam int WORD_BYTES = 4;

endpackage

// ===== design/masked_byte_signature_search.sv =====
// masked byte signature search, top level
// depends on mbss_pkg and assert_macros.svh
//
// usage:
//   input channel (i_in_valid / o_in_ready) takes one region byte per
//   transaction with its address and a region end flag.
//   output channel (o_out_valid / i_out_ready) gives zero or one result per
//   byte: a found result for the first masked match in a region, or a
//   not-found result on the region end byte if nothing matched.
//   config channel (i_cfg_valid / o_cfg_ready) writes one register per
//   transaction; o_cfg_ready is always high. write only while idle.
// path: a byte's result passes through the input register, then the result
//   register, before it reaches the output.
// throughput: one byte per cycle while the output is not stalled; the window
//   compare of all positions is done combinationally between the input register and the result register.
// reset: synchronous, active low; clears the window, fill count, match flag,
//   all pipeline valids and returns the configuration registers to defaults.
// stall: while a result waits on a low i_out_ready, the input register
//   holds and o_in_ready falls once it is full; nothing is dropped.

`timescale 1ns / 1ps

`include "assert_macros.svh"

module masked_byte_signature_search
    import mbss_pkg::*;
#(
    parameter int PATTERN_MAX   = 24,
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_byte_address,
    input  logic        i_region_end,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_scan_status,
    output logic [31:0] o_result_offset
);

    localparam int LEN_CAP = (PATTERN_MAX < REG_PATTERN_BYTES) ? PATTERN_MAX
                                                               : REG_PATTERN_BYTES;
    localparam int CW      = $clog2(PATTERN_MAX + 1);
    localparam int AW      = ADDRESS_WIDTH;

    // configuration registers
    logic [63:0] r_pattern_low;
    logic [63:0] r_pattern_mid;
    logic [63:0] r_pattern_high;
    logic [23:0] r_care_mask;
    logic [4:0]  r_pattern_length;
    logic [4:0]  r_extract_position;
    logic [1:0]  r_address_mode;
    logic [31:0] r_base_address;

    // config-derived compare setup, aligned to window positions
    logic [7:0]             r_al_pat  [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_al_care;
    logic [PATTERN_MAX-1:0] r_xsel    [WORD_BYTES];
    logic [CW-1:0]          r_len_eff;
    logic [7:0]             n_al_pat  [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] n_al_care;
    logic [PATTERN_MAX-1:0] n_xsel    [WORD_BYTES];
    logic [CW-1:0]          c_len;

    // input register
    logic          r_a_valid;
    logic [7:0]    r_a_data;
    logic [AW-1:0] r_a_where;
    logic          r_a_last;

    // region state
    logic [7:0]    r_win [PATTERN_MAX];
    logic [CW-1:0] r_fill;
    logic          r_match_done;
    logic [7:0]    n_win [PATTERN_MAX];
    logic [CW-1:0] n_fill;

    // result register
    logic          r_out_valid;
    logic          r_out_status;
    logic [31:0]   r_out_offset;

    logic                   out_free;
    logic                   proc;
    logic [PATTERN_MAX-1:0] byte_ok;
    logic                   hit;
    logic                   emit;
    logic [31:0]            word;
    logic [AW-1:0]          mode_val;
    logic [AW-1:0]          value;

    assign o_cfg_ready = 1'b1;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low      <= '0;
            r_pattern_mid      <= '0;
            r_pattern_high     <= '0;
            r_care_mask        <= '0;
            r_pattern_length   <= 5'd1;
            r_extract_position <= '0;
            r_address_mode     <= '0;
            r_base_address     <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_PATTERN_LOW:      r_pattern_low      <= i_cfg_data;
                REG_PATTERN_MID:      r_pattern_mid      <= i_cfg_data;
                REG_PATTERN_HIGH:     r_pattern_high     <= i_cfg_data;
                REG_CARE_MASK:        r_care_mask        <= i_cfg_data[23:0];
                REG_PATTERN_LENGTH:   r_pattern_length   <= i_cfg_data[4:0];
                REG_EXTRACT_POSITION: r_extract_position <= i_cfg_data[4:0];
                REG_ADDRESS_MODE:     r_address_mode     <= i_cfg_data[1:0];
                REG_BASE_ADDRESS:     r_base_address     <= i_cfg_data[31:0];
            endcase
        end
    end

    // effective pattern length, clamped to one and to the smaller of the window size and the pattern register bytes
    always_comb begin
        if (r_pattern_length == '0) begin
            c_len = CW'(1);
        end else if (int'(r_pattern_length) > LEN_CAP) begin
            c_len = CW'(LEN_CAP);
        end else begin
            c_len = CW'(r_pattern_length);
        end
    end

    // map pattern bytes and word bytes onto window positions (newest at 0)
    always_comb begin
        logic [PATTERN_BITS-1:0] pat_all;
        int                      k;
        int                      t;
        pat_all = {r_pattern_high, r_pattern_mid, r_pattern_low};
        for (int j = 0; j < PATTERN_MAX; j++) begin
            k = int'(c_len) - 1 - j;
            if (j < int'(c_len)) begin
                n_al_pat[j]  = pat_all[8*k +: 8];
                n_al_care[j] = r_care_mask[k];
            end else begin
                n_al_pat[j]  = '0;
                n_al_care[j] = 1'b0;
            end
        end
        for (int m = 0; m < WORD_BYTES; m++) begin
            t         = int'(r_extract_position) + m;
            n_xsel[m] = '0;
            for (int j = 0; j < PATTERN_MAX; j++) begin
                n_xsel[m][j] = (t < int'(c_len)) && (j == int'(c_len) - 1 - t);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_al_pat  <= n_al_pat;
        r_al_care <= n_al_care;
        r_xsel    <= n_xsel;
        r_len_eff <= c_len;
    end

    // handshake
    assign out_free   = !r_out_valid || i_out_ready;
    assign proc       = r_a_valid && out_free;
    assign o_in_ready = !r_a_valid || out_free;

    // input register; match address is formed here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_a_data  <= i_data_byte;
            r_a_where <= AW'(i_byte_address) - (AW'(c_len) - AW'(1));
            r_a_last  <= i_region_end;
        end
    end

    // shifted window and saturating fill count
    always_comb begin
        n_win[0] = r_a_data;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            n_win[j] = r_win[j-1];
        end
        n_fill = (r_fill < CW'(PATTERN_MAX)) ? r_fill + CW'(1) : r_fill;
    end

    // parallel masked compare of all window positions
    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            byte_ok[j] = !r_al_care[j] || (n_win[j] == r_al_pat[j]);
        end
    end

    assign hit  = !r_match_done && (n_fill >= r_len_eff) && (&byte_ok);
    assign emit = hit || (r_a_last && !r_match_done);

    // extracted little-endian word, and-or select from the window
    always_comb begin
        word = '0;
        for (int m = 0; m < WORD_BYTES; m++) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                word[8*m +: 8] = word[8*m +: 8] | (n_win[j] & {8{r_xsel[m][j]}});
            end
        end
    end

    // result value
    always_comb begin
        unique case (r_address_mode)
            MODE_WORD:      mode_val = AW'(word);
            MODE_ADDR_PLUS: mode_val = r_a_where + AW'(word);
            default:        mode_val = r_a_where;
        endcase
        value = mode_val - AW'(r_base_address);
    end

    // region state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_win[j] <= '0;
            end
            r_fill       <= '0;
            r_match_done <= 1'b0;
        end else if (proc) begin
            if (r_a_last) begin
                for (int j = 0; j < PATTERN_MAX; j++) begin
                    r_win[j] <= '0;
                end
                r_fill       <= '0;
                r_match_done <= 1'b0;
            end else begin
                r_win        <= n_win;
                r_fill       <= n_fill;
                r_match_done <= r_match_done || hit;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc && emit) begin
            r_out_status <= hit ? STATUS_FOUND : STATUS_NOT_FOUND;
            r_out_offset <= hit ? 32'(value) : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_scan_status   = r_out_status;
    assign o_result_offset = r_out_offset;

    // checks
    `ASSERT_NEXT(a_region_clear, i_clk, i_rst_n, proc && r_a_last,
        r_fill == '0 && !r_match_done, "region state not cleared after region end")
    `ASSERT_NEXT(a_match_sticks, i_clk, i_rst_n, proc && hit && !r_a_last,
        r_match_done, "match flag not set after a found result")
    `ASSERT_IMPLIES(a_not_found_zero, i_clk, i_rst_n,
        r_out_valid && r_out_status == STATUS_NOT_FOUND, r_out_offset == '0,
        "not-found result with nonzero offset")

endmodule
